>>> rtl/tbqm_pkg.sv
// Shared types, register map and quarter-wave sine generator for the tone bank mixer.
package tbqm_pkg;

    localparam int MAX_TONES_DEF      = 4;
    localparam int SINE_ADDR_BITS_DEF = 10;

    // Per-tone step registers and register map
    localparam int STEP_REGS = 4;
    localparam int REG_COUNT = 1 + STEP_REGS;
    localparam int PADDR_W   = $clog2(REG_COUNT * 4);
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TONE_COUNT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TONE0_STEP = REG_IDX_W'(1);

    localparam logic [2:0] TONE_COUNT_RST = 3'd1;

    // Q30 polynomial coefficients for sin(pi/2 * x)
    localparam longint QC1 = 64'sd1686629713;
    localparam longint QC3 = -64'sd693598668;
    localparam longint QC5 = 64'sd85569306;
    localparam longint QC7 = -64'sd5026995;
    localparam longint QC9 = 64'sd172272;

    typedef struct packed {
        logic [2:0]                  tone_count;
        logic [STEP_REGS-1:0][31:0]  step;
    } cfg_t;

    // Q30 multiply, rounded half away from zero
    function automatic longint mulq30(input longint a, input longint b);
        longint ua;
        longint ub;
        longint r;
        logic   neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        r   = (ua * ub + (longint'(1) << 29)) >>> 30;
        return neg ? -r : r;
    endfunction

    // Quarter-wave sine entry j for a table of 2^(addr_bits-2) steps, Q15
    function automatic logic [14:0] quarter_sine(input int j, input int addr_bits);
        longint x;
        longint x2;
        longint t;
        longint y;
        longint s;
        x  = longint'(j) << (30 - (addr_bits - 2));
        x2 = mulq30(x, x);
        t  = QC7 + mulq30(x2, QC9);
        t  = QC5 + mulq30(x2, t);
        t  = QC3 + mulq30(x2, t);
        t  = QC1 + mulq30(x2, t);
        y  = mulq30(x, t);
        if (y < 0) begin
            s = 0;
        end else begin
            s = (y + (longint'(1) << 14)) >>> 15;
            if (s > 32767) begin
                s = 32767;
            end
        end
        return s[14:0];
    endfunction

endpackage

>>> rtl/tbqm_cfg.sv
// APB register block: tone count and per-tone phase steps.
module tbqm_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbqm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tbqm_pkg::cfg_t                cfg
);

    logic [tbqm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;
    tbqm_pkg::cfg_t                 cfg_reg;
    tbqm_pkg::cfg_t                 cfg_next;

    assign reg_idx = paddr[tbqm_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            if (reg_idx == tbqm_pkg::REG_TONE_COUNT) begin
                cfg_next.tone_count = pwdata[2:0];
            end
            for (int i = 0; i < tbqm_pkg::STEP_REGS; i++) begin
                if (int'(reg_idx) == int'(tbqm_pkg::REG_TONE0_STEP) + i) begin
                    cfg_next.step[i] = pwdata;
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == tbqm_pkg::REG_TONE_COUNT) begin
            prdata = {29'd0, cfg_reg.tone_count};
        end
        for (int i = 0; i < tbqm_pkg::STEP_REGS; i++) begin
            if (int'(reg_idx) == int'(tbqm_pkg::REG_TONE0_STEP) + i) begin
                prdata = cfg_reg.step[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tone_count <= tbqm_pkg::TONE_COUNT_RST;
            cfg_reg.step       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/tbqm_cell.sv
// One phase accumulator cell of the rotating phase ring.
module tbqm_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  logic [31:0] phase_in,
    output logic [31:0] phase_out
);

    logic [31:0] phase_reg;

    assign phase_out = phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (shift_en) begin
            phase_reg <= phase_in;
        end
    end

endmodule

>>> rtl/tbqm_sine.sv
// Quarter-wave sine/cosine lookup with quadrant folding, registered output.
module tbqm_sine #(
    parameter int SINE_ADDR_BITS = tbqm_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [SINE_ADDR_BITS-1:0] idx,
    output logic signed [15:0]        sin_val,
    output logic signed [15:0]        cos_val
);

    localparam int QN_W = SINE_ADDR_BITS - 2;
    localparam int QN   = 1 << QN_W;
    localparam int RA_W = QN_W + 1;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    logic [14:0]          qs_rom [0:QN];
    quad_t                quad;
    logic [QN_W-1:0]      j;
    logic [RA_W-1:0]      lo_addr;
    logic [RA_W-1:0]      hi_addr;
    logic signed [15:0]   lo;
    logic signed [15:0]   hi;
    logic signed [15:0]   sin_next;
    logic signed [15:0]   cos_next;
    logic signed [15:0]   sin_reg;
    logic signed [15:0]   cos_reg;

    for (genvar g = 0; g <= QN; g++) begin : g_rom
        assign qs_rom[g] = tbqm_pkg::quarter_sine(g, SINE_ADDR_BITS);
    end

    assign quad    = quad_t'(idx[SINE_ADDR_BITS-1 -: 2]);
    assign j       = idx[QN_W-1:0];
    assign lo_addr = {1'b0, j};
    assign hi_addr = RA_W'(QN) - lo_addr;
    assign lo      = $signed({1'b0, qs_rom[lo_addr]});
    assign hi      = $signed({1'b0, qs_rom[hi_addr]});

    always_comb begin
        unique case (quad)
            QUAD_0: begin
                sin_next = lo;
                cos_next = hi;
            end
            QUAD_1: begin
                sin_next = hi;
                cos_next = -lo;
            end
            QUAD_2: begin
                sin_next = -lo;
                cos_next = -hi;
            end
            QUAD_3: begin
                sin_next = -hi;
                cos_next = lo;
            end
            default: begin
                sin_next = '0;
                cos_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

>>> rtl/tone_bank_quadrature_mixer.sv
// Tone bank quadrature mixer: ring of phase cells, sine lookup, mix and output register.
//
// Each accepted audio sample is mixed against every active tone in tone order, one
// I/Q result per cycle while the output is not stalled, with the last result of the
// sample flagged. Tone phases sit in a ring of MAX_TONES cells that rotates once per
// sample, so a new sample is taken only when the ring is idle or finishing its
// rotation, whatever the tone count. A result passes through the sine and product
// registers into the output register after its tone reaches the head of the ring.
// While a result waits, a new sample can still be taken if the ring is idle, and the
// whole datapath holds while the result side stalls. No clearing pass after reset.
module tone_bank_quadrature_mixer #(
    parameter int MAX_TONES      = tbqm_pkg::MAX_TONES_DEF,
    parameter int SINE_ADDR_BITS = tbqm_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_tone_index,
    output logic signed [15:0]            m_in_phase,
    output logic signed [15:0]            m_quadrature,
    output logic                          m_last_tone,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbqm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int TONE_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int CAP    = (MAX_TONES < tbqm_pkg::STEP_REGS) ? MAX_TONES
                                                             : tbqm_pkg::STEP_REGS;

    tbqm_pkg::cfg_t      cfg;
    logic [2:0]          n_eff;
    logic                adv;
    logic                k_last;
    logic                accept;
    logic                shift_en;
    logic                active;
    logic [31:0]         step_sel;
    logic [31:0]         head_upd;
    logic [31:0]         phase [MAX_TONES];

    logic                busy_reg;
    logic                busy_next;
    logic [TONE_W-1:0]   k_reg;
    logic [TONE_W-1:0]   k_next;
    logic signed [15:0]  sample_reg;

    // stage 2: alongside the sine lookup
    logic                v2_reg;
    logic signed [15:0]  sample2_reg;
    logic [1:0]          tone2_reg;
    logic                last2_reg;
    logic signed [15:0]  sin_val;
    logic signed [15:0]  cos_val;

    // stage 3: products
    logic                v3_reg;
    logic [1:0]          tone3_reg;
    logic                last3_reg;
    logic signed [31:0]  prod_i_reg;
    logic signed [31:0]  prod_q_reg;

    // stage 4: output register
    logic                out_valid_reg;
    logic [1:0]          out_tone_reg;
    logic                out_last_reg;
    logic signed [15:0]  out_i_reg;
    logic signed [15:0]  out_q_reg;
    logic signed [15:0]  out_i_next;
    logic signed [15:0]  out_q_next;

    function automatic logic signed [15:0] round_sat(input logic signed [31:0] p);
        logic signed [32:0] r;
        r = ($signed({p[31], p}) + 33'sd16384) >>> 15;
        if (r > 33'sd32767) begin
            return 16'sh7fff;
        end else if (r < -33'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    tbqm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero tones counts as one, too many is clamped
    always_comb begin
        if (cfg.tone_count == 3'd0) begin
            n_eff = 3'd1;
        end else if (int'(cfg.tone_count) > CAP) begin
            n_eff = 3'(CAP);
        end else begin
            n_eff = cfg.tone_count;
        end
    end

    assign adv      = !out_valid_reg || m_ready;
    assign k_last   = (k_reg == TONE_W'(MAX_TONES - 1));
    assign s_ready  = !busy_reg || (adv && k_last);
    assign accept   = s_valid && s_ready;
    assign shift_en = busy_reg && adv;
    assign active   = int'(k_reg) < int'(n_eff);

    always_comb begin
        step_sel = '0;
        for (int i = 0; i < tbqm_pkg::STEP_REGS; i++) begin
            if (int'(k_reg) == i) begin
                step_sel = cfg.step[i];
            end
        end
    end

    assign head_upd = active ? (phase[0] + step_sel) : phase[0];

    // head phase re-enters at the tail, so the ring is home after MAX_TONES shifts
    for (genvar g = 0; g < MAX_TONES; g++) begin : g_ring
        if (g == MAX_TONES - 1) begin : g_tail
            tbqm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .phase_in  (head_upd),
                .phase_out (phase[g])
            );
        end else begin : g_body
            tbqm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .phase_in  (phase[g+1]),
                .phase_out (phase[g])
            );
        end
    end

    tbqm_sine #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine (
        .aclk    (aclk),
        .en      (adv),
        .idx     (phase[0][31 -: SINE_ADDR_BITS]),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    always_comb begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (shift_en) begin
            k_next = k_last ? '0 : k_reg + TONE_W'(1);
            if (k_last) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    assign out_i_next = round_sat(prod_i_reg);
    assign out_q_next = round_sat(prod_q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            if (adv) begin
                v2_reg        <= busy_reg && active;
                v3_reg        <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        if (adv) begin
            sample2_reg  <= sample_reg;
            tone2_reg    <= 2'(k_reg);
            last2_reg    <= (int'(k_reg) == int'(n_eff) - 1);
            tone3_reg    <= tone2_reg;
            last3_reg    <= last2_reg;
            prod_i_reg   <= 32'(sample2_reg) * 32'(cos_val);
            prod_q_reg   <= 32'(sample2_reg) * 32'(sin_val);
            out_tone_reg <= tone3_reg;
            out_last_reg <= last3_reg;
            out_i_reg    <= out_i_next;
            out_q_reg    <= out_q_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_tone_index = out_tone_reg;
    assign m_in_phase   = out_i_reg;
    assign m_quadrature = out_q_reg;
    assign m_last_tone  = out_last_reg;

    // last flag only on the final active tone
    a_last_tone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_tone |-> int'(m_tone_index) == int'(n_eff) - 1)
        else $error("last_tone flagged on a tone that is not the final one");

    // ring sits at home whenever no sample is in progress
    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> k_reg == '0)
        else $error("phase ring not at home position while idle");

    // a sample only enters when the ring is free or finishing its last shift
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !(adv && k_last) |-> !s_ready)
        else $error("input taken while ring still rotating");

    // a stalled output holds the whole datapath
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && busy_reg |=> $stable(k_reg))
        else $error("ring advanced while result side stalled");

endmodule
